// File: design/cfr_pkg.sv
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 49;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNC_LIMIT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_LIMIT   = 2'd3;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND_RST = 8'hAF;
  localparam logic [8:0] FUNC_LIMIT_RST  = 9'h0F1;
  localparam logic [5:0] LEN_LIMIT_RST   = 6'd50;

  localparam logic [7:0] ACK_FUNC_LO = 8'h10;
  localparam logic [7:0] ACK_FUNC_HI = 8'h15;

  typedef struct packed {
    logic sum_load;
    logic sum_add;
    logic func_load;
    logic len_load;
    logic byte_store;
    logic rd_clear;
    logic rd_fetch;
    logic rd_next;
  } cfr_cmd_t;

  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic func_ok;
    logic len_ok;
    logic left_zero;
    logic left_one;
    logic sum_hit;
    logic rd_last;
  } cfr_sts_t;

endpackage

// File: design/cfr_in_if.sv
`timescale 1ns / 1ps

interface cfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/cfr_out_if.sv
`timescale 1ns / 1ps

interface cfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] function_code;
  logic [5:0] payload_length;
  logic [5:0] byte_index;
  logic [7:0] payload_byte;
  logic [7:0] frame_checksum;
  logic       ack_needed;
  logic       last;

  modport source (output valid, output function_code, output payload_length,
                  output byte_index, output payload_byte, output frame_checksum,
                  output ack_needed, output last, input ready);
  modport sink   (input valid, input function_code, input payload_length,
                  input byte_index, input payload_byte, input frame_checksum,
                  input ack_needed, input last, output ready);
endinterface

// File: design/checksummed_frame_receiver.sv
`timescale 1ns / 1ps

// Checksummed frame receiver.
// in_chan carries one received byte per request (valid/ready). The block hunts
// for sync_first, sync_second, a function byte, a length byte, the payload and
// an additive 8-bit checksum. out_chan carries one request per payload byte of
// a frame whose checksum matched, in index order, with last on the final one.
// Bad or malformed frames produce nothing and hunting restarts.
// On a good checksum byte the receiver stops taking bytes and reads the
// payload store one entry at a time: S_READ fetches an entry and S_SHOW then
// holds it as a valid result until out_chan.ready takes it; the next entry is
// then fetched, or after the final one hunting resumes.
// A stall on out_chan holds the current result stable and holds off in_chan.
// cfg_we writes register cfg_idx (0 sync_first, 1 sync_second,
// 2 function_limit, 3 length_limit) from cfg_data; write only while idle.
// Synchronous reset (rst_n low) restores default registers and hunting; the
// payload store is not cleared and needs no clearing pass.

module checksummed_frame_receiver
  import cfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  cfr_in_if.sink                in_chan,
  cfr_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfr_cmd_t cmd;
  cfr_sts_t sts;

  cfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_data       (cfg_data),
    .rx_byte        (in_chan.rx_byte),
    .cmd            (cmd),
    .sts            (sts),
    .function_code  (out_chan.function_code),
    .payload_length (out_chan.payload_length),
    .byte_index     (out_chan.byte_index),
    .payload_byte   (out_chan.payload_byte),
    .frame_checksum (out_chan.frame_checksum),
    .ack_needed     (out_chan.ack_needed),
    .last           (out_chan.last)
  );

`ifndef SYNTHESIS
  a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.byte_index < out_chan.payload_length))
    else $error("result index beyond frame length");

  a_last_resumes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && out_chan.last) |=> in_chan.ready)
    else $error("receiver did not resume after final result");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.ready && !out_chan.last) |=> !out_chan.valid ##1
      (out_chan.valid && (out_chan.byte_index == $past(out_chan.byte_index, 2) + 6'd1)))
    else $error("result index did not advance by one");
`endif

endmodule

// File: design/cfr_datapath.sv
`timescale 1ns / 1ps

module cfr_datapath
  import cfr_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [7:0]            rx_byte,
  input  cfr_cmd_t              cmd,
  output cfr_sts_t              sts,
  output logic [7:0]            function_code,
  output logic [5:0]            payload_length,
  output logic [5:0]            byte_index,
  output logic [7:0]            payload_byte,
  output logic [7:0]            frame_checksum,
  output logic                  ack_needed,
  output logic                  last
);

  localparam int AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int LIM_CAP = MAX_PAYLOAD + 1;

  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  logic [8:0] func_limit_r;
  logic [5:0] len_limit_r;

  logic [5:0] bytes_left_r;
  logic [5:0] write_index_r;
  logic [7:0] running_sum_r;
  logic [7:0] held_function_r;
  logic [5:0] rd_idx_r;

  logic [7:0] store_mem [MAX_PAYLOAD];
  logic [7:0] rd_data_r;

  logic [6:0] len_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
      func_limit_r  <= FUNC_LIMIT_RST;
      len_limit_r   <= LEN_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_SYNC_FIRST:  sync_first_r  <= cfg_data[7:0];
        CFG_SYNC_SECOND: sync_second_r <= cfg_data[7:0];
        CFG_FUNC_LIMIT:  func_limit_r  <= cfg_data;
        CFG_LEN_LIMIT:   len_limit_r   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r    <= '0;
      write_index_r   <= '0;
      running_sum_r   <= '0;
      held_function_r <= '0;
      rd_idx_r        <= '0;
    end else begin
      if (cmd.sum_load) begin
        running_sum_r <= rx_byte;
      end else if (cmd.sum_add) begin
        running_sum_r <= running_sum_r + rx_byte;
      end
      if (cmd.func_load) begin
        held_function_r <= rx_byte;
      end
      if (cmd.len_load) begin
        bytes_left_r  <= rx_byte[5:0];
        write_index_r <= '0;
      end else if (cmd.byte_store) begin
        bytes_left_r  <= bytes_left_r - 6'd1;
        write_index_r <= write_index_r + 6'd1;
      end
      if (cmd.rd_clear) begin
        rd_idx_r <= '0;
      end else if (cmd.rd_next) begin
        rd_idx_r <= rd_idx_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_store) begin
      store_mem[write_index_r[AW-1:0]] <= rx_byte;
    end
    if (cmd.rd_fetch) begin
      rd_data_r <= store_mem[rd_idx_r[AW-1:0]];
    end
  end

  // length byte limit, capped at the store depth plus one
  assign len_lim = ({1'b0, len_limit_r} > 7'(LIM_CAP)) ? 7'(LIM_CAP) : {1'b0, len_limit_r};

  always_comb begin
    sts.sync1_hit = (rx_byte == sync_first_r);
    sts.sync2_hit = (rx_byte == sync_second_r);
    sts.func_ok   = ({1'b0, rx_byte} < func_limit_r);
    sts.len_ok    = (rx_byte < {1'b0, len_lim});
    sts.left_zero = (bytes_left_r == 6'd0);
    sts.left_one  = (bytes_left_r == 6'd1);
    sts.sum_hit   = (rx_byte == running_sum_r);
    sts.rd_last   = (rd_idx_r == write_index_r - 6'd1);
  end

  assign function_code  = held_function_r;
  assign payload_length = write_index_r;
  assign byte_index     = rd_idx_r;
  assign payload_byte   = rd_data_r;
  assign frame_checksum = running_sum_r;
  assign ack_needed     = (held_function_r >= ACK_FUNC_LO) && (held_function_r <= ACK_FUNC_HI);
  assign last           = sts.rd_last;

`ifndef SYNTHESIS
  a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_store |-> (write_index_r < 6'(MAX_PAYLOAD)))
    else $error("payload write beyond store");

  a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.len_load |-> (rx_byte <= 8'(MAX_PAYLOAD)))
    else $error("accepted length exceeds store");

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.byte_store |=> (write_index_r == $past(write_index_r) + 6'd1) &&
                       (bytes_left_r == $past(bytes_left_r) - 6'd1))
    else $error("fill counters out of step");
`endif

endmodule

// File: design/cfr_ctrl.sv
`timescale 1ns / 1ps

module cfr_ctrl
  import cfr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  cfr_sts_t sts,
  output cfr_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_SYNC1,
    S_SYNC2,
    S_FUNC,
    S_LEN,
    S_PAY,
    S_CHK,
    S_READ,
    S_SHOW
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;

  assign in_ready  = (state_r != S_READ) && (state_r != S_SHOW);
  assign take      = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_SYNC1: begin
        if (take && sts.sync1_hit) begin
          cmd.sum_load = 1'b1;
          state_nxt    = S_SYNC2;
        end
      end
      S_SYNC2: begin
        if (take) begin
          cmd.sum_add = sts.sync2_hit;
          state_nxt   = sts.sync2_hit ? S_FUNC : S_SYNC1;
        end
      end
      S_FUNC: begin
        if (take) begin
          cmd.sum_add   = sts.func_ok;
          cmd.func_load = sts.func_ok;
          state_nxt     = sts.func_ok ? S_LEN : S_SYNC1;
        end
      end
      S_LEN: begin
        if (take) begin
          cmd.sum_add  = sts.len_ok;
          cmd.len_load = sts.len_ok;
          state_nxt    = sts.len_ok ? S_PAY : S_SYNC1;
        end
      end
      S_PAY: begin
        if (take) begin
          if (sts.left_zero) begin
            state_nxt = S_SYNC1;
          end else begin
            cmd.sum_add    = 1'b1;
            cmd.byte_store = 1'b1;
            state_nxt      = sts.left_one ? S_CHK : S_PAY;
          end
        end
      end
      S_CHK: begin
        if (take) begin
          cmd.rd_clear = sts.sum_hit;
          state_nxt    = sts.sum_hit ? S_READ : S_SYNC1;
        end
      end
      S_READ: begin
        cmd.rd_fetch  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_SHOW;
      end
      S_SHOW: begin
        out_valid_nxt = 1'b1;
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (sts.rd_last) begin
            state_nxt = S_SYNC1;
          end else begin
            cmd.rd_next = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SYNC1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_show_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r == (state_r == S_SHOW))
    else $error("result valid out of step with state");

  a_no_rx_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready)
    else $error("request taken while a result is pending");

  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && take && sts.sum_hit) |=> (state_r == S_READ) ##1 out_valid_r)
    else $error("good frame did not start emission");
`endif

endmodule
